// ===== rtl/core/lfpd_pkg.sv =====
// Shared types and constants for the line follower PD drive block.
package lfpd_pkg;

	localparam int SENSOR_W = 10;
	localparam int NUM_LINE_SENSORS = 6;

	typedef enum logic [2:0] {
		DIR_STOP  = 3'd0,
		DIR_FWD   = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_BACK  = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		REG_PROP  = 3'd0,
		REG_INTEG = 3'd1,
		REG_DERIV = 3'd2,
		REG_THR   = 3'd3,
		REG_SETPT = 3'd4,
		REG_MAXSP = 3'd5,
		REG_TURN  = 3'd6,
		REG_MARK  = 3'd7
	} reg_idx_t;

	localparam logic [11:0] HOLD_STOP = 12'd4000;
	localparam logic [11:0] HOLD_SPIN = 12'd50;

	typedef struct packed {
		logic                                          manual_mode;
		logic [NUM_LINE_SENSORS-1:0][SENSOR_W-1:0]     line;
		logic [SENSOR_W-1:0]                           joy_x;
		logic [SENSOR_W-1:0]                           joy_y;
	} frame_t;

	typedef struct packed {
		logic [7:0]  left_duty;
		logic [7:0]  right_duty;
		logic [2:0]  drive_dir;
		logic [11:0] hold_ms;
		logic [12:0] line_position;
		logic        position_valid;
	} result_t;

endpackage

// ===== rtl/core/line_follower_pd_drive_top.sv =====
// Top level of the line follower PD drive block.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  frame   | frame_valid frame_stall frame  | in
//  command | cmd_valid cmd_stall cmd        | out
//  config  | cfg_we cfg_index cfg_data      | in
//
// One frame is in work at a time; frame_stall is high whenever the core is busy.
// A manual frame goes from capture straight to hand-off; all-on-line, corner and
// faint frames go from the sum to hand-off. A PID frame passes capture, sum, divider
// load, 32 divider steps, error update, products, sum, scale by 1/10, clamp, hand-off.
// The finished command goes to the output register; a stalled command there
// holds the core in its hand-off state until transfer, and no new frame is
// taken meanwhile. Reset restores register defaults and clears the PID state.
module line_follower_pd_drive_top (
	input  logic clk,
	input  logic arst_n,
	input  logic frame_valid,
	output logic frame_stall,
	input  lfpd_pkg::frame_t frame,
	output logic cmd_valid,
	input  logic cmd_stall,
	output lfpd_pkg::result_t cmd,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [14:0] cfg_data
);
	localparam int NS  = lfpd_pkg::NUM_LINE_SENSORS;
	localparam int SW  = lfpd_pkg::SENSOR_W;
	localparam int WW  = $clog2(NS + 1);
	localparam int TW  = SW + WW + $clog2(NS + 1);
	localparam int NW  = 32;
	localparam int DW  = SW + $clog2(NS + 1);
	// ceil(2^28 / 10): exact floor division by ten for magnitudes below 2^26
	localparam logic [24:0] RECIP10 = 25'd26843546;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SUM, ST_DIV, ST_PID, ST_MUL, ST_SCALE, ST_CLAMP, ST_OUT
	} state_t;

	// configuration registers
	logic [7:0]  prop_q, integ_q, deriv_q, maxsp_q, turn_q;
	logic [9:0]  thr_q;
	logic [12:0] setpt_q;
	logic [14:0] mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= 8'd4;
			integ_q <= 8'd0;
			deriv_q <= 8'd20;
			thr_q   <= 10'd800;
			setpt_q <= 13'd3500;
			maxsp_q <= 8'd255;
			turn_q  <= 8'd150;
			mark_q  <= 15'd30000;
		end else if (cfg_we) begin
			unique case (lfpd_pkg::reg_idx_t'(cfg_index))
				lfpd_pkg::REG_PROP:  prop_q  <= cfg_data[7:0];
				lfpd_pkg::REG_INTEG: integ_q <= cfg_data[7:0];
				lfpd_pkg::REG_DERIV: deriv_q <= cfg_data[7:0];
				lfpd_pkg::REG_THR:   thr_q   <= cfg_data[9:0];
				lfpd_pkg::REG_SETPT: setpt_q <= cfg_data[12:0];
				lfpd_pkg::REG_MAXSP: maxsp_q <= cfg_data[7:0];
				lfpd_pkg::REG_TURN:  turn_q  <= cfg_data[7:0];
				lfpd_pkg::REG_MARK:  mark_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// captured frame
	logic [SW-1:0] sens_q [NS];
	logic [SW-1:0] min_q;

	// frame minimum: comparison chain over independent lanes' inputs
	logic [SW-1:0] fmin;
	always_comb begin
		fmin = frame.line[0];
		for (int i = 1; i < NS; i++)
			if (frame.line[i] < fmin) fmin = frame.line[i];
	end

	// lanes work on the stored frame
	logic [NS-1:0] on_l;
	logic [SW-1:0]    off_l  [NS];
	logic [SW+WW-1:0] term_l [NS];
	for (genvar g = 0; g < NS; g++) begin : g_lane
		lfpd_lane #(.WEIGHT(g + 1), .WW(WW)) u_lane (
			.reading(sens_q[g]), .frame_min(min_q), .threshold(thr_q),
			.on_line(on_l[g]), .offset(off_l[g]), .term(term_l[g])
		);
	end

	// merge: sums of lane outputs
	logic [TW-1:0] tot_c;
	logic [DW-1:0] wt_c;
	always_comb begin
		tot_c = '0;
		wt_c  = '0;
		for (int i = 0; i < NS; i++) begin
			tot_c = tot_c + TW'(term_l[i]);
			wt_c  = wt_c + DW'(off_l[i]);
		end
	end

	localparam int LO = (NS > 3) ? NS - 3 : 0;
	localparam int HI3 = (NS > 3) ? 3 : NS;
	logic all_on, left_on, right_on, short_c;
	assign all_on   = &on_l;
	assign left_on  = &on_l[HI3-1:0];
	assign right_on = &on_l[NS-1:LO];
	// stop, corner spin or faint frame: no PID step
	assign short_c  = all_on || left_on || right_on || (wt_c < DW'(100));

	lfpd_pkg::result_t sum_r;
	always_comb begin
		sum_r = '0;
		sum_r.drive_dir = lfpd_pkg::DIR_STOP;
		if (all_on) begin
			sum_r.hold_ms = lfpd_pkg::HOLD_STOP;
		end else if (left_on || right_on) begin
			sum_r.left_duty  = turn_q;
			sum_r.right_duty = turn_q;
			sum_r.drive_dir  = left_on ? lfpd_pkg::DIR_LEFT : lfpd_pkg::DIR_RIGHT;
			sum_r.hold_ms    = lfpd_pkg::HOLD_SPIN;
		end
	end

	// manual windows
	logic [9:0] jx, jy;
	logic xmid, ymid, man_hit;
	lfpd_pkg::result_t man_r;
	assign jx = frame.joy_x;
	assign jy = frame.joy_y;
	assign xmid = jx > 10'd450 && jx < 10'd700;
	assign ymid = jy > 10'd400 && jy < 10'd600;
	always_comb begin
		man_r = '0;
		man_hit = 1'b1;
		priority if (xmid && ymid) man_r.drive_dir = lfpd_pkg::DIR_STOP;
		else if (jx > 10'd800 && ymid) begin
			man_r.left_duty = turn_q; man_r.right_duty = turn_q;
			man_r.drive_dir = lfpd_pkg::DIR_LEFT;
		end else if (jx < 10'd400 && ymid) begin
			man_r.left_duty = turn_q; man_r.right_duty = turn_q;
			man_r.drive_dir = lfpd_pkg::DIR_RIGHT;
		end else if (jx > 10'd500 && jx < 10'd600 && jy > 10'd600 && jy < 10'd950) begin
			man_r.left_duty = 8'd150; man_r.right_duty = 8'd150;
			man_r.drive_dir = lfpd_pkg::DIR_FWD;
		end else if (jx > 10'd450 && jx < 10'd600 && jy > 10'd950) begin
			man_r.left_duty = 8'd255; man_r.right_duty = 8'd255;
			man_r.drive_dir = lfpd_pkg::DIR_FWD;
		end else if (xmid && jy > 10'd100 && jy < 10'd450) begin
			man_r.left_duty = 8'd150; man_r.right_duty = 8'd150;
			man_r.drive_dir = lfpd_pkg::DIR_BACK;
		end else if (xmid && jy < 10'd100) begin
			man_r.left_duty = 8'd255; man_r.right_duty = 8'd255;
			man_r.drive_dir = lfpd_pkg::DIR_BACK;
		end else man_hit = 1'b0;
	end

	// divider
	logic          div_start_q, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] wt_q;
	logic [TW-1:0] tot_q;
	assign div_num = NW'(tot_q) * NW'(1000);
	lfpd_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(div_num),
		.den(wt_q), .done(div_done), .quo(div_quo)
	);

	state_t state_q;
	logic [12:0] pos_q;
	logic signed [15:0] prev_q, isum_q, err_q, der_q;
	logic signed [25:0] pp_q, ip_q, dp_q;
	logic [24:0] mag_q;
	logic        neg_q;
	logic [21:0] q10_q;
	logic out_full_q, out_load;
	lfpd_pkg::result_t res_q, out_q;

	assign frame_stall = (state_q != ST_IDLE);
	assign cmd_valid   = out_full_q;
	assign cmd         = out_q;
	// advance the finished command when the output register is free or draining
	assign out_load    = (state_q == ST_OUT) && (!out_full_q || !cmd_stall);

	logic signed [15:0] err_c, isum_c;
	assign err_c  = 16'(div_quo) - 16'(setpt_q);
	assign isum_c = (isum_q == $signed({1'b0, mark_q}) ||
	                 isum_q == -$signed({1'b0, mark_q})) ? 16'sd0 : isum_q;

	// correction: magnitude and sign, then truncate toward zero by scaling
	logic signed [27:0] sum_c;
	logic [27:0] abs_c;
	logic [49:0] scale_c;
	logic [7:0]  lim_c;
	assign sum_c   = 28'(pp_q) + 28'(ip_q) + 28'(dp_q);
	assign abs_c   = sum_c[27] ? -sum_c : sum_c;
	assign scale_c = 50'(mag_q) * 50'(RECIP10);
	assign lim_c   = (q10_q > 22'(maxsp_q)) ? maxsp_q : q10_q[7:0];

	lfpd_pkg::result_t pid_r;
	always_comb begin
		pid_r = '0;
		pid_r.drive_dir = lfpd_pkg::DIR_FWD;
		pid_r.line_position = pos_q;
		pid_r.position_valid = 1'b1;
		if (neg_q) begin
			pid_r.left_duty  = maxsp_q - lim_c;
			pid_r.right_duty = maxsp_q;
		end else begin
			pid_r.left_duty  = maxsp_q;
			pid_r.right_duty = maxsp_q - lim_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_full_q  <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
			prev_q      <= '0;
			isum_q      <= '0;
			err_q       <= '0;
			der_q       <= '0;
			pos_q       <= '0;
			pp_q        <= '0;
			ip_q        <= '0;
			dp_q        <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			q10_q       <= '0;
			tot_q       <= '0;
			wt_q        <= '0;
			min_q       <= '0;
			div_start_q <= 1'b0;
			for (int i = 0; i < NS; i++)
				sens_q[i] <= '0;
		end else begin
			div_start_q <= (state_q == ST_SUM) && !short_c;
			if (out_load) begin
				out_q      <= res_q;
				out_full_q <= 1'b1;
			end else if (out_full_q && !cmd_stall) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (frame_valid && !frame_stall) begin
					if (frame.manual_mode) begin
						// drop frames with no matching window
						if (man_hit) begin
							res_q   <= man_r;
							state_q <= ST_OUT;
						end
					end else begin
						for (int i = 0; i < NS; i++)
							sens_q[i] <= frame.line[i];
						min_q   <= fmin;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (short_c) begin
						res_q   <= sum_r;
						state_q <= ST_OUT;
					end else begin
						tot_q   <= tot_c;
						wt_q    <= wt_c;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: if (div_done) begin
					pos_q  <= div_quo[12:0];
					err_q  <= err_c;
					der_q  <= err_c - prev_q;
					isum_q <= isum_c + err_c;
					prev_q <= err_c;
					state_q <= ST_PID;
				end
				ST_PID: begin
					pp_q <= err_q * $signed({1'b0, prop_q});
					ip_q <= isum_q * $signed({1'b0, integ_q});
					dp_q <= der_q * $signed({1'b0, deriv_q});
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mag_q   <= abs_c[24:0];
					neg_q   <= sum_c[27];
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					q10_q   <= scale_c[49:28];
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					res_q   <= pid_r;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/lfpd_lane.sv =====
// One sensor lane: on-line test, offset from the frame minimum and weighted term.
module lfpd_lane #(
	parameter int WEIGHT = 1,
	parameter int WW = 5
) (
	input  logic [lfpd_pkg::SENSOR_W-1:0] reading,
	input  logic [lfpd_pkg::SENSOR_W-1:0] frame_min,
	input  logic [lfpd_pkg::SENSOR_W-1:0] threshold,
	output logic                          on_line,
	output logic [lfpd_pkg::SENSOR_W-1:0] offset,
	output logic [lfpd_pkg::SENSOR_W+WW-1:0] term
);
	assign on_line = reading >= threshold;
	assign offset  = reading - frame_min;
	assign term    = offset * WW'(WEIGHT);
endmodule

// ===== rtl/core/lfpd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lfpd_div #(
	parameter int NW = 32,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q[DW-1:0], n_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign quo   = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				n_q   <= {n_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				n_q   <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
